/* hdl/mlc_pkg.sv */
// Shared types, constants and tables for the mouse-look camera orientation unit.
package mlc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_ITER_DEF     = 16;

  // CORDIC angle grid is 1/2^20 degree; vectors are Q30.
  localparam int CW_FRAC  = 20;
  localparam int VEC_W    = 34;
  localparam int PROD_W   = 2 * VEC_W;
  localparam int ZW       = 30;
  localparam int ATAN_W   = 26;
  localparam int NUM_W    = 48;
  localparam int DEN_W    = 32;
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int UNIT_Q14 = 16384;

  localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032875);

  typedef enum logic [2:0] {
    CFG_SENSITIVITY = 3'd0,
    CFG_SPEED       = 3'd1,
    CFG_UP_X        = 3'd2,
    CFG_UP_Y        = 3'd3,
    CFG_UP_Z        = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CUR_DX,
    ST_CUR_DY,
    ST_CUR_PITCH,
    ST_CUR_MOD,
    ST_MV_VEL,
    ST_MV_LOAD,
    ST_MV_KEY,
    ST_MV_MUL,
    ST_MV_ADD,
    ST_ANG,
    ST_CYAW,
    ST_CPIT,
    ST_DX,
    ST_DZ,
    ST_DV,
    ST_NSQ,
    ST_NACC,
    ST_NSQRT,
    ST_NDIV,
    ST_NDWAIT,
    ST_XMUL,
    ST_XACC,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    VS_DIR,
    VS_RGT,
    VS_TOP
  } vsel_e;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic               key_forward;
    logic               key_back;
    logic               key_left;
    logic               key_right;
    logic [15:0]        delta_time;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic signed [15:0] direction_x;
    logic signed [15:0] direction_y;
    logic signed [15:0] direction_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] camera_up_x;
    logic signed [15:0] camera_up_y;
    logic signed [15:0] camera_up_z;
  } out_t;

  // atan(2^-i) in 1/2^20 degree.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      5'd0:    r = 26'd47185920;
      5'd1:    r = 26'd27855475;
      5'd2:    r = 26'd14718068;
      5'd3:    r = 26'd7471121;
      5'd4:    r = 26'd3750058;
      5'd5:    r = 26'd1876857;
      5'd6:    r = 26'd938658;
      5'd7:    r = 26'd469357;
      5'd8:    r = 26'd234682;
      5'd9:    r = 26'd117342;
      5'd10:   r = 26'd58671;
      5'd11:   r = 26'd29335;
      5'd12:   r = 26'd14668;
      5'd13:   r = 26'd7334;
      5'd14:   r = 26'd3667;
      5'd15:   r = 26'd1833;
      5'd16:   r = 26'd917;
      5'd17:   r = 26'd458;
      5'd18:   r = 26'd229;
      5'd19:   r = 26'd115;
      5'd20:   r = 26'd57;
      5'd21:   r = 26'd29;
      5'd22:   r = 26'd14;
      5'd23:   r = 26'd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hdl/mlc_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
module mlc_cordic import mlc_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ZW-1:0]    z_i,
  output logic                    done_o,
  output logic signed [VEC_W-1:0] cos_o,
  output logic signed [VEC_W-1:0] sin_o
);

  localparam int CNT_W = $clog2(CORDIC_ITERATIONS);

  logic                    busy_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [VEC_W-1:0] x_q, y_q;
  logic signed [ZW-1:0]    z_q;
  logic signed [ZW-1:0]    atan_s;

  assign atan_s = ZW'(atan_deg(5'(cnt_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= CORDIC_GAIN;
      y_q <= '0;
      z_q <= z_i;
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - (y_q >>> cnt_q);
        y_q <= y_q + (x_q >>> cnt_q);
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + (y_q >>> cnt_q);
        y_q <= y_q - (x_q >>> cnt_q);
        z_q <= z_q + atan_s;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = x_q;
  assign sin_o  = y_q;

endmodule

/* hdl/mlc_isqrt.sv */
// Integer square root, two radicand bits per cycle.
module mlc_isqrt import mlc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   value_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  logic            busy_q, done_q;
  logic [SQ_W-1:0] v_q, r_q, bit_q;
  logic [SQ_W-1:0] trial;
  logic            take;

  assign trial = r_q + bit_q;
  assign take  = (v_q >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (take) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

/* hdl/mlc_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module mlc_divider import mlc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // Quotient bits shift in behind the dividend bits as they leave.
      if (fits) begin
        rem_q <= DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DEN_W-1:0];
      end
      num_q <= {num_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/mouse_look_camera_orientation.sv */
// Top level of the fly-camera orientation unit: sequencer, shared multiplier and state.
// One input transaction is worked at a time and yields one result transaction. A cursor
// transaction updates yaw (with a bit-serial modulo) and clamped pitch; a movement
// transaction steps position one axis at a time for each held key. Both then run the
// CORDIC twice and normalize three vectors, each with a square root and three divisions,
// plus two cross products. The bit-serial divider serves all nine normalized components.
// The next transaction is taken while the previous result still waits in the output register.
module mouse_look_camera_orientation import mlc_pkg::*; #(
  parameter int ANGLE_FRAC_BITS   = ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int S_SH    = 16 - ANGLE_FRAC_BITS;
  localparam int CW_SH   = CW_FRAC - ANGLE_FRAC_BITS;
  localparam int FULL_I  = 360 << ANGLE_FRAC_BITS;
  localparam int LIM_I   = 89 << ANGLE_FRAC_BITS;
  localparam int YAW_W   = $clog2(FULL_I);
  localparam int PITCH_W = $clog2(LIM_I) + 1;
  localparam int OW      = 40;
  localparam int AW      = 31;

  localparam logic signed [PROD_W-1:0] OFF_RND  = PROD_W'(64'd1 << (S_SH - 1));
  localparam logic signed [PROD_W-1:0] DIR_RND  = PROD_W'(64'd1 << 29);
  localparam logic signed [PROD_W-1:0] MOVE_RND = PROD_W'(64'd1 << 21);
  localparam logic signed [OW-1:0]     LIM_S    = OW'(LIM_I);
  localparam logic [DEN_W-1:0]         FULL_U   = DEN_W'(FULL_I);
  localparam logic signed [AW-1:0]     HALF_S   = AW'(180 << CW_FRAC);
  localparam logic signed [AW-1:0]     QUART_S  = AW'(90 << CW_FRAC);

  st_e   state_q, state_d;
  in_t   in_q;
  out_t  out_q;
  logic  out_valid_q;
  vsel_e vsel_q;

  logic [15:0]        sens_q, speed_q;
  logic signed [15:0] up_q [3];

  logic                    first_q;
  logic signed [15:0]      prev_x_q, prev_y_q;
  logic [YAW_W-1:0]        yaw_q;
  logic signed [PITCH_W-1:0] pitch_q;
  logic signed [31:0]      pos_q [3];
  logic signed [15:0]      dir_q [3];
  logic signed [15:0]      rgt_q [3];
  logic signed [15:0]      top_q [3];

  logic signed [16:0]      dy_q;
  logic signed [OW-1:0]    yw_q;
  logic [31:0]             vel_q;
  logic [1:0]              kidx_q, comp_q;
  logic [2:0]              j_q;
  logic                    flip_q;
  logic signed [VEC_W-1:0] cy_q, sy_q, cp_q, sp_q, t_q;
  logic signed [VEC_W-1:0] v_q [3];
  logic [SQ_W-1:0]         acc_q;
  logic [ROOT_W-1:0]       len_q;

  logic signed [VEC_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_q;

  logic                    cor_start, cor_done;
  logic signed [ZW-1:0]    cor_z;
  logic signed [VEC_W-1:0] cor_cos, cor_sin;
  logic                    sq_start, sq_done;
  logic [SQ_W-1:0]         sq_val, acc_next;
  logic [ROOT_W-1:0]       sq_root;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_num, div_quot;
  logic [DEN_W-1:0]        div_den, div_rem;

  // Cursor arithmetic.
  logic signed [15:0]   px_sel, py_sel;
  logic signed [16:0]   dx, dy_new;
  logic signed [OW-1:0] off, yw_new, pt_sum, yw_abs;
  logic signed [PITCH_W-1:0] pt_clamp;

  // Yaw folding into [-90, 90].
  logic signed [AW-1:0] a0, a1, a2;
  logic                 fold_flip;
  logic signed [ZW-1:0] yaw_z, pitch_z;

  // Movement and normalization.
  logic [3:0]              keys;
  logic signed [15:0]      mv_vec;
  logic signed [VEC_W-1:0] move_st, abs_v, v_cur;
  logic signed [VEC_W:0]   pos_sum;
  logic signed [31:0]      pos_sat;
  logic                    mv_neg;
  logic [14:0]             nq;
  logic signed [15:0]      norm_val;
  logic                    norm_wr, norm_last;

  // Cross product operands.
  logic [1:0]         xc, xi1, xi2;
  logic signed [15:0] xa, xb;

  function automatic logic [1:0] inc3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic signed [15:0] pick3(input logic signed [15:0] v0,
                                               input logic signed [15:0] v1,
                                               input logic signed [15:0] v2,
                                               input logic [1:0] c);
    logic signed [15:0] r;
    case (c)
      2'd0:    r = v0;
      2'd1:    r = v1;
      default: r = v2;
    endcase
    return r;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- combinational datapath ----------------
  assign px_sel = first_q ? in_q.cursor_x : prev_x_q;
  assign py_sel = first_q ? in_q.cursor_y : prev_y_q;
  assign dx     = {in_q.cursor_x[15], in_q.cursor_x} - {px_sel[15], px_sel};
  assign dy_new = {py_sel[15], py_sel} - {in_q.cursor_y[15], in_q.cursor_y};

  assign off    = OW'((prod_q + OFF_RND) >>> S_SH);
  assign yw_new = OW'({1'b0, yaw_q}) + off;
  assign pt_sum = OW'(pitch_q) + off;
  assign yw_abs = yw_q[OW-1] ? -yw_q : yw_q;

  always_comb begin
    if (pt_sum > LIM_S) begin
      pt_clamp = PITCH_W'(LIM_S);
    end else if (pt_sum < -LIM_S) begin
      pt_clamp = PITCH_W'(-LIM_S);
    end else begin
      pt_clamp = PITCH_W'(pt_sum);
    end
  end

  always_comb begin
    a0 = AW'({1'b0, yaw_q}) <<< CW_SH;
    a1 = (a0 >= HALF_S) ? a0 - (HALF_S <<< 1) : a0;
    fold_flip = 1'b0;
    a2 = a1;
    if (a1 > QUART_S) begin
      a2 = a1 - HALF_S;
      fold_flip = 1'b1;
    end else if (a1 < -QUART_S) begin
      a2 = a1 + HALF_S;
      fold_flip = 1'b1;
    end
  end

  assign yaw_z   = ZW'(a2);
  assign pitch_z = ZW'(pitch_q) <<< CW_SH;

  assign keys    = {in_q.key_right, in_q.key_left, in_q.key_back, in_q.key_forward};
  assign mv_vec  = kidx_q[1] ? rgt_q[comp_q] : dir_q[comp_q];
  assign mv_neg  = (kidx_q == 2'd1) || (kidx_q == 2'd2);
  assign move_st = VEC_W'((prod_q + MOVE_RND) >>> 22);
  assign pos_sum = mv_neg ? (VEC_W'(pos_q[comp_q]) - move_st) : (VEC_W'(pos_q[comp_q]) + move_st);

  always_comb begin
    if (pos_sum > (VEC_W + 1)'(32'sh7FFF_FFFF)) begin
      pos_sat = 32'sh7FFF_FFFF;
    end else if (pos_sum < -(VEC_W + 1)'(33'sh0_8000_0000)) begin
      pos_sat = 32'sh8000_0000;
    end else begin
      pos_sat = 32'(pos_sum);
    end
  end

  assign v_cur    = v_q[comp_q];
  assign abs_v    = v_cur[VEC_W-1] ? -v_cur : v_cur;
  assign acc_next = ((comp_q == 2'd0) ? '0 : acc_q) + SQ_W'(prod_q);
  assign nq       = (div_quot > NUM_W'(UNIT_Q14)) ? 15'(UNIT_Q14) : div_quot[14:0];
  assign norm_val = (len_q == '0) ? 16'sd0 : (v_cur[VEC_W-1] ? -{1'b0, nq} : {1'b0, nq});
  assign norm_wr  = ((state_q == ST_NDIV) && (len_q == '0)) ||
                    ((state_q == ST_NDWAIT) && div_done);
  assign norm_last = (comp_q == 2'd2);

  assign xc  = j_q[2:1];
  assign xi1 = inc3(xc);
  assign xi2 = inc3(xi1);

  always_comb begin
    logic [1:0] ia, ib;
    ia = j_q[0] ? xi2 : xi1;
    ib = j_q[0] ? xi1 : xi2;
    if (vsel_q == VS_RGT) begin
      xa = pick3(dir_q[0], dir_q[1], dir_q[2], ia);
      xb = pick3(up_q[0], up_q[1], up_q[2], ib);
    end else begin
      xa = pick3(rgt_q[0], rgt_q[1], rgt_q[2], ia);
      xb = pick3(dir_q[0], dir_q[1], dir_q[2], ib);
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = in_data_i.operation ? ST_MV_VEL : ST_CUR_DX;
      ST_CUR_DX:    state_d = ST_CUR_DY;
      ST_CUR_DY:    state_d = ST_CUR_PITCH;
      ST_CUR_PITCH: state_d = ST_CUR_MOD;
      ST_CUR_MOD:   if (div_done) state_d = ST_ANG;
      ST_MV_VEL:    state_d = ST_MV_LOAD;
      ST_MV_LOAD:   state_d = ST_MV_KEY;
      ST_MV_KEY: begin
        if (keys[kidx_q]) begin
          state_d = ST_MV_MUL;
        end else if (kidx_q == 2'd3) begin
          state_d = ST_ANG;
        end
      end
      ST_MV_MUL:    state_d = ST_MV_ADD;
      ST_MV_ADD: begin
        if (comp_q != 2'd2) begin
          state_d = ST_MV_MUL;
        end else begin
          state_d = (kidx_q == 2'd3) ? ST_ANG : ST_MV_KEY;
        end
      end
      ST_ANG:       state_d = ST_CYAW;
      ST_CYAW:      if (cor_done) state_d = ST_CPIT;
      ST_CPIT:      if (cor_done) state_d = ST_DX;
      ST_DX:        state_d = ST_DZ;
      ST_DZ:        state_d = ST_DV;
      ST_DV:        state_d = ST_NSQ;
      ST_NSQ:       state_d = ST_NACC;
      ST_NACC:      state_d = (comp_q == 2'd2) ? ST_NSQRT : ST_NSQ;
      ST_NSQRT:     if (sq_done) state_d = ST_NDIV;
      ST_NDIV, ST_NDWAIT: begin
        if (state_q == ST_NDIV && len_q != '0) begin
          state_d = ST_NDWAIT;
        end else if (norm_wr) begin
          if (!norm_last) begin
            state_d = ST_NDIV;
          end else begin
            state_d = (vsel_q == VS_TOP) ? ST_DONE : ST_XMUL;
          end
        end
      end
      ST_XMUL:      state_d = ST_XACC;
      ST_XACC:      state_d = (j_q == 3'd5) ? ST_NSQ : ST_XMUL;
      ST_DONE:      if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // ---------------- unit controls and multiplier operands ----------------
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    cor_start = 1'b0;
    cor_z     = yaw_z;
    sq_start  = 1'b0;
    sq_val    = acc_next;
    div_start = 1'b0;
    div_num   = NUM_W'(unsigned'(yw_abs));
    div_den   = FULL_U;
    case (state_q)
      ST_CUR_DX: begin
        mul_a = VEC_W'(dx);
        mul_b = VEC_W'({1'b0, sens_q});
      end
      ST_CUR_DY: begin
        mul_a = VEC_W'(dy_q);
        mul_b = VEC_W'({1'b0, sens_q});
      end
      ST_CUR_PITCH: div_start = 1'b1;
      ST_MV_VEL: begin
        mul_a = VEC_W'({1'b0, speed_q});
        mul_b = VEC_W'({1'b0, in_q.delta_time});
      end
      ST_MV_MUL: begin
        mul_a = VEC_W'({1'b0, vel_q});
        mul_b = VEC_W'(mv_vec);
      end
      ST_ANG: cor_start = 1'b1;
      ST_CYAW: begin
        cor_start = cor_done;
        cor_z     = pitch_z;
      end
      ST_DX: begin
        mul_a = cy_q;
        mul_b = cp_q;
      end
      ST_DZ: begin
        mul_a = sy_q;
        mul_b = cp_q;
      end
      ST_NSQ: begin
        mul_a = abs_v;
        mul_b = abs_v;
      end
      ST_NACC: sq_start = (comp_q == 2'd2);
      ST_NDIV: begin
        div_start = (len_q != '0);
        div_num   = (NUM_W'(unsigned'(abs_v)) << 14) + NUM_W'(len_q >> 1);
        div_den   = len_q;
      end
      ST_XMUL: begin
        mul_a = VEC_W'(xa);
        mul_b = VEC_W'(xb);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      sens_q      <= 16'd6554;
      speed_q     <= 16'd640;
      up_q[0]     <= 16'sd0;
      up_q[1]     <= 16'sd16384;
      up_q[2]     <= 16'sd0;
      first_q     <= 1'b1;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      yaw_q       <= YAW_W'(270 << ANGLE_FRAC_BITS);
      pitch_q     <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      pos_q[2]    <= 32'sd393216;
      dir_q[0]    <= '0;
      dir_q[1]    <= '0;
      dir_q[2]    <= -16'sd16384;
      rgt_q[0]    <= 16'sd16384;
      rgt_q[1]    <= '0;
      rgt_q[2]    <= '0;
      top_q[0]    <= '0;
      top_q[1]    <= 16'sd16384;
      top_q[2]    <= '0;
      vsel_q      <= VS_DIR;
      comp_q      <= '0;
      kidx_q      <= '0;
      j_q         <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SENSITIVITY: sens_q  <= cfg_data_i;
          CFG_SPEED:       speed_q <= cfg_data_i;
          CFG_UP_X:        up_q[0] <= cfg_data_i;
          CFG_UP_Y:        up_q[1] <= cfg_data_i;
          CFG_UP_Z:        up_q[2] <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CUR_DX: begin
          prev_x_q <= in_q.cursor_x;
          prev_y_q <= in_q.cursor_y;
          first_q  <= 1'b0;
        end
        ST_CUR_PITCH: pitch_q <= pt_clamp;
        ST_CUR_MOD: begin
          if (div_done) begin
            if (yw_q[OW-1] && div_rem != '0) begin
              yaw_q <= YAW_W'(FULL_U - div_rem);
            end else begin
              yaw_q <= YAW_W'(div_rem);
            end
          end
        end
        ST_MV_LOAD: kidx_q <= '0;
        ST_MV_KEY: begin
          if (keys[kidx_q]) begin
            comp_q <= '0;
          end else begin
            kidx_q <= kidx_q + 2'd1;
          end
        end
        ST_MV_ADD: begin
          pos_q[comp_q] <= pos_sat;
          if (comp_q == 2'd2) begin
            comp_q <= '0;
            kidx_q <= kidx_q + 2'd1;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_DV: begin
          comp_q <= '0;
          vsel_q <= VS_DIR;
        end
        ST_NACC: comp_q <= (comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1;
        ST_NDIV, ST_NDWAIT: begin
          if (norm_wr) begin
            case (vsel_q)
              VS_DIR:  dir_q[comp_q] <= norm_val;
              VS_RGT:  rgt_q[comp_q] <= norm_val;
              default: top_q[comp_q] <= norm_val;
            endcase
            if (norm_last) begin
              comp_q <= '0;
              j_q    <= '0;
              if (vsel_q == VS_DIR) begin
                vsel_q <= VS_RGT;
              end else if (vsel_q == VS_RGT) begin
                vsel_q <= VS_TOP;
              end
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        ST_XACC: begin
          j_q <= j_q + 3'd1;
          if (j_q == 3'd5) begin
            comp_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- work registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    case (state_q)
      ST_CUR_DX:  dy_q  <= dy_new;
      ST_CUR_DY:  yw_q  <= yw_new;
      ST_MV_LOAD: vel_q <= prod_q[31:0];
      ST_ANG:     flip_q <= fold_flip;
      ST_CYAW: begin
        if (cor_done) begin
          cy_q <= flip_q ? -cor_cos : cor_cos;
          sy_q <= flip_q ? -cor_sin : cor_sin;
        end
      end
      ST_CPIT: begin
        if (cor_done) begin
          cp_q <= cor_cos;
          sp_q <= cor_sin;
        end
      end
      ST_DZ:      v_q[0] <= VEC_W'((prod_q + DIR_RND) >>> 30);
      ST_DV: begin
        v_q[2] <= VEC_W'((prod_q + DIR_RND) >>> 30);
        v_q[1] <= sp_q;
      end
      ST_NACC:    acc_q <= acc_next;
      ST_NSQRT:   if (sq_done) len_q <= sq_root;
      ST_XACC: begin
        if (!j_q[0]) begin
          t_q <= VEC_W'(prod_q);
        end else begin
          v_q[xc] <= t_q - VEC_W'(prod_q);
        end
      end
      ST_DONE: begin
        // The output register is loaded only once the previous result has left.
        if (!out_valid_q || out_ready_i) begin
          out_q.position_x  <= pos_q[0];
          out_q.position_y  <= pos_q[1];
          out_q.position_z  <= pos_q[2];
          out_q.direction_x <= dir_q[0];
          out_q.direction_y <= dir_q[1];
          out_q.direction_z <= dir_q[2];
          out_q.right_x     <= rgt_q[0];
          out_q.right_y     <= rgt_q[1];
          out_q.right_z     <= rgt_q[2];
          out_q.camera_up_x <= top_q[0];
          out_q.camera_up_y <= top_q[1];
          out_q.camera_up_z <= top_q[2];
        end
      end
      default: ;
    endcase
  end

  mlc_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z_i     (cor_z),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  mlc_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  mlc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

endmodule
